/* rtl/ppc_pkg.sv */
package ppc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int OFF_W = 34;
    localparam int NUM_W = 52;
    localparam int QUO_W = 52;

    localparam logic [1:0] REG_NORMAL_X = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [1:0] REG_PLANE_D  = 2'd3;

    typedef enum logic [2:0] {
        CLS_UNKNOWN = 3'd0,
        CLS_INFRONT = 3'd1,
        CLS_BEHIND  = 3'd2,
        CLS_EXITS   = 3'd3,
        CLS_ENTERS  = 3'd4
    } cls_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT,
        ST_EDGE,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [OFF_W:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [15:0]      quo;
    } div_rsp_t;

    function automatic cls_t classify(input logic signed [OFF_W-1:0] a,
                                      input logic signed [OFF_W-1:0] b,
                                      input cls_t prev);
        cls_t r;
        r = prev;
        if (b > 0)
        begin
            if (a > 0) r = CLS_INFRONT;
            else if (a < 0) r = CLS_ENTERS;
            else r = (prev == CLS_BEHIND) ? CLS_ENTERS : CLS_INFRONT;
        end
        else if (b < 0)
        begin
            if (a < 0) r = CLS_BEHIND;
            else if (a > 0) r = CLS_EXITS;
            else r = (prev == CLS_INFRONT) ? CLS_EXITS : CLS_BEHIND;
        end
        else if (a > 0) r = CLS_INFRONT;
        else if (a < 0) r = CLS_BEHIND;
        return r;
    endfunction

endpackage

/* rtl/ppc_if.sv */
interface ppc_vertex_if;
    import ppc_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               is_last;
    modport source (output valid, vertex_x, vertex_y, vertex_z, is_last, input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, is_last, output ready);
    modport monitor (input valid, vertex_x, vertex_y, vertex_z, is_last, ready);
endinterface

interface ppc_result_if;
    import ppc_pkg::*;
    logic               valid;
    logic               ready;
    logic               found;
    logic [5:0]         enter_edge;
    logic [5:0]         exit_edge;
    logic signed [15:0] enter_x;
    logic signed [15:0] enter_y;
    logic signed [15:0] enter_z;
    logic signed [15:0] exit_x;
    logic signed [15:0] exit_y;
    logic signed [15:0] exit_z;
    modport source (output valid, found, enter_edge, exit_edge, enter_x, enter_y, enter_z,
                    exit_x, exit_y, exit_z, input ready);
    modport sink (input valid, found, enter_edge, exit_edge, enter_x, enter_y, enter_z,
                  exit_x, exit_y, exit_z, output ready);
    modport monitor (input valid, found, enter_edge, exit_edge, enter_x, enter_y, enter_z,
                     exit_x, exit_y, exit_z, ready);
endinterface

/* rtl/ppc_div.sv */
module ppc_div
    import ppc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // restoring divide, one quotient bit per cycle, round half away from zero
    localparam int CW = $clog2(QUO_W + 1);

    logic               busy_reg, busy_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [NUM_W:0]     n_reg, n_next;      // 2|num| + |den|
    logic [NUM_W+1:0]   rem_reg, rem_next;
    logic [NUM_W:0]     q_reg, q_next;
    logic [OFF_W+1:0]   d_reg, d_next;      // 2|den|
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;

    logic [NUM_W-1:0]   un;
    logic [OFF_W:0]     ud;
    logic [NUM_W+1:0]   trial;
    logic [NUM_W:0]     qs;

    always_comb
    begin
        un = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        ud = req.den[OFF_W] ? (OFF_W+1)'(-req.den) : (OFF_W+1)'(req.den);
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = '0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W + 1);
            n_next    = {un, 1'b0} + (NUM_W+1)'(ud);
            d_next    = {ud, 1'b0};
            rem_next  = '0;
            q_next    = '0;
            neg_next  = req.num[NUM_W-1] ^ req.den[OFF_W];
        end
        else if (busy_reg)
        begin
            trial  = {rem_reg[NUM_W:0], n_reg[NUM_W]};
            n_next = {n_reg[NUM_W-1:0], 1'b0};
            if (trial >= (NUM_W+2)'(d_reg))
            begin
                rem_next = trial - (NUM_W+2)'(d_reg);
                q_next   = {q_reg[NUM_W-1:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[NUM_W-1:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign qs = neg_reg ? (NUM_W+1)'(-q_reg) : q_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = qs[15:0];

endmodule

/* rtl/polygon_plane_crossing.sv */
// polygon_plane_crossing
// finds where one closed polygon crosses a plane given by a q1.14 normal
// and an offset; the plane is set through the write port (cfg_we, cfg_index,
// cfg_data) and is to be written by the user only while the block is idle;
// the block itself does not enforce this; vertices arrive on the vtx channel
// in order, is_last on the final one; after the last vertex one result
// request goes out on the res channel with found, the entering and exiting
// edge indices and the rounded crossing points (all zero when the polygon
// does not cross)
// a vertex is accepted, then its plane offset is formed on the shared 16x35
// multiplier, followed by its edge and bookkeeping (the first vertex of a
// polygon has no edge); a crossing edge adds, per coordinate, its products,
// a divider start and the serial divide, which is the longest step
// the last vertex also runs the closing edge and the output state, where the
// result register is loaded
// the block accepts one vertex at a time and is not ready while it works
// the result sits in an output register until taken; vertices of the next
// polygon are still accepted, and a stalled receiver only holds the block
// once the next result is ready to load
// reset clears the polygon state and loads the plane normal (0, 0, 1.0) and
// offset 0
module polygon_plane_crossing
    import ppc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    ppc_vertex_if.sink   vtx,
    ppc_result_if.source res
);

    // plane registers
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic signed [31:0] pd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= 16'sd16384;
            pd_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NORMAL_X: nx_reg <= cfg_data[15:0];
                REG_NORMAL_Y: ny_reg <= cfg_data[15:0];
                REG_NORMAL_Z: nz_reg <= cfg_data[15:0];
                REG_PLANE_D:  pd_reg <= cfg_data;
                default:      pd_reg <= pd_reg;
            endcase
        end
    end

    state_t state_reg, state_next;

    // current vertex
    logic signed [15:0]      cv_reg [3];
    logic                    last_reg;
    logic signed [OFF_W-1:0] coff_reg, coff_next;
    logic [1:0]              step_reg, step_next;
    logic [1:0]              coord_reg, coord_next;

    // polygon state
    logic signed [15:0]      fv_reg [3];
    logic signed [15:0]      pv_reg [3];
    logic signed [OFF_W-1:0] poff_reg, foff_reg;
    cls_t                    cls_reg;
    logic [CNT_W-1:0]        vcnt_reg;
    logic                    ens_reg, exs_reg;
    logic [IDX_W-1:0]        eni_reg, exi_reg;
    logic signed [15:0]      enp_reg [3];
    logic signed [15:0]      exp_reg [3];

    // edge being processed: regular edge prev -> current, closing edge
    // current -> first
    logic signed [15:0]      eo [3];
    logic signed [15:0]      ee [3];
    logic signed [15:0]      eo_c, ee_c;
    logic signed [OFF_W-1:0] ea, eb;
    logic signed [OFF_W:0]   den_w;
    logic [IDX_W-1:0]        eidx;
    cls_t                    ecls;
    logic                    closing_reg;
    logic                    isen_reg;
    logic signed [NUM_W-1:0] acc_reg, acc_next;

    // shared multiplier: 16 x 35 signed
    logic signed [15:0]      mul_a;
    logic signed [OFF_W:0]   mul_b;
    logic signed [NUM_W-1:0] mul_p;
    assign mul_p = NUM_W'(mul_a * mul_b);

    div_req_t dreq;
    div_rsp_t drsp;
    ppc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic                    out_valid_reg;
    logic                    found_reg;
    logic [5:0]              oen_reg, oex_reg;
    logic signed [15:0]      opt_reg [6];
    logic                    out_load;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eo[i] = closing_reg ? cv_reg[i] : pv_reg[i];
            ee[i] = closing_reg ? fv_reg[i] : cv_reg[i];
        end
        case (coord_reg)
            2'd0:
            begin
                eo_c = eo[0];
                ee_c = ee[0];
            end
            2'd1:
            begin
                eo_c = eo[1];
                ee_c = ee[1];
            end
            default:
            begin
                eo_c = eo[2];
                ee_c = ee[2];
            end
        endcase
        ea = closing_reg ? coff_reg : poff_reg;
        eb = closing_reg ? foff_reg : coff_reg;
    end

    // regular edge runs before the count advances, closing edge after it,
    // so both take count - 1 (saturation keeps it at the top index)
    assign eidx  = IDX_W'(vcnt_reg - CNT_W'(1));
    assign den_w = (OFF_W+1)'(ea) - (OFF_W+1)'(eb);
    assign ecls  = classify(ea, eb, cls_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        coord_next = coord_reg;
        coff_next  = coff_reg;
        acc_next   = acc_reg;
        mul_a      = '0;
        mul_b      = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (vtx.valid)
                begin
                    state_next = ST_DOT;
                    step_next  = '0;
                end
            end
            ST_DOT:
            begin
                // pd - x*nx - y*ny - z*nz, one product per step
                case (step_reg)
                    2'd0:
                    begin
                        mul_a = cv_reg[0];
                        mul_b = (OFF_W+1)'(nx_reg);
                    end
                    2'd1:
                    begin
                        mul_a = cv_reg[1];
                        mul_b = (OFF_W+1)'(ny_reg);
                    end
                    default:
                    begin
                        mul_a = cv_reg[2];
                        mul_b = (OFF_W+1)'(nz_reg);
                    end
                endcase
                if (step_reg == 2'd0)
                    coff_next = OFF_W'(pd_reg) - OFF_W'(mul_p);
                else
                    coff_next = coff_reg - OFF_W'(mul_p);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                    state_next = (vcnt_reg == '0) ? ST_NEXT : ST_EDGE;
            end
            ST_EDGE:
            begin
                // skip once both edges are known, or when no crossing;
                // an edge lying in the plane takes its origin directly
                if ((ens_reg && exs_reg) ||
                    (ecls != CLS_ENTERS && ecls != CLS_EXITS) || den_w == '0)
                    state_next = closing_reg ? ST_OUT : ST_NEXT;
                else
                begin
                    step_next  = '0;
                    coord_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // a*e - b*o for one coordinate, first product then difference
                if (step_reg == 2'd0)
                begin
                    mul_a     = ee_c;
                    mul_b     = (OFF_W+1)'(ea);
                    acc_next  = mul_p;
                    step_next = 2'd1;
                end
                else
                begin
                    mul_a      = eo_c;
                    mul_b      = (OFF_W+1)'(eb);
                    acc_next   = acc_reg - mul_p;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    if (coord_reg == 2'd2)
                        state_next = closing_reg ? ST_OUT : ST_NEXT;
                    else
                    begin
                        coord_next = coord_reg + 2'd1;
                        step_next  = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_NEXT:
            begin
                state_next = last_reg ? ST_EDGE : ST_IDLE;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // divider started in the cycle after the numerator is complete
    always_comb
    begin
        dreq.start = (state_reg == ST_DIV);
        dreq.num   = acc_reg;
        dreq.den   = den_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            coord_reg     <= '0;
            cls_reg       <= CLS_UNKNOWN;
            vcnt_reg      <= '0;
            ens_reg       <= 1'b0;
            exs_reg       <= 1'b0;
            eni_reg       <= '0;
            exi_reg       <= '0;
            closing_reg   <= 1'b0;
            isen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            coord_reg <= coord_next;
            case (state_reg)
                ST_EDGE:
                begin
                    if (!(ens_reg && exs_reg))
                    begin
                        cls_reg <= ecls;
                        if (ecls == CLS_ENTERS)
                        begin
                            ens_reg  <= 1'b1;
                            eni_reg  <= eidx;
                            isen_reg <= 1'b1;
                        end
                        else if (ecls == CLS_EXITS)
                        begin
                            exs_reg  <= 1'b1;
                            exi_reg  <= eidx;
                            isen_reg <= 1'b0;
                        end
                    end
                end
                ST_NEXT:
                begin
                    if (vcnt_reg < CNT_W'(MAX_VERTICES))
                        vcnt_reg <= vcnt_reg + CNT_W'(1);
                    closing_reg <= last_reg;
                end
                ST_OUT:
                begin
                    // hand off the result and clear the polygon
                    if (out_load)
                    begin
                        found_reg   <= ens_reg && exs_reg;
                        cls_reg     <= CLS_UNKNOWN;
                        vcnt_reg    <= '0;
                        ens_reg     <= 1'b0;
                        exs_reg     <= 1'b0;
                        eni_reg     <= '0;
                        exi_reg     <= '0;
                        closing_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && vtx.valid)
        begin
            cv_reg[0] <= vtx.vertex_x;
            cv_reg[1] <= vtx.vertex_y;
            cv_reg[2] <= vtx.vertex_z;
            last_reg  <= vtx.is_last;
        end
        coff_reg <= coff_next;
        acc_reg  <= acc_next;
        // vertex bookkeeping once its regular edge is done
        if (state_reg == ST_NEXT)
        begin
            if (vcnt_reg == '0)
            begin
                for (int i = 0; i < 3; i++)
                    fv_reg[i] <= cv_reg[i];
                foff_reg <= coff_reg;
            end
            for (int i = 0; i < 3; i++)
                pv_reg[i] <= cv_reg[i];
            poff_reg <= coff_reg;
        end
        // edge in the plane carrying a crossing class: point is its origin
        if (state_reg == ST_EDGE && !(ens_reg && exs_reg) && den_w == '0)
        begin
            if (ecls == CLS_ENTERS)
            begin
                for (int i = 0; i < 3; i++)
                    enp_reg[i] <= eo[i];
            end
            else if (ecls == CLS_EXITS)
            begin
                for (int i = 0; i < 3; i++)
                    exp_reg[i] <= eo[i];
            end
        end
        if (state_reg == ST_WAIT && drsp.done)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (coord_reg == 2'(i))
                begin
                    if (isen_reg)
                        enp_reg[i] <= drsp.quo;
                    else
                        exp_reg[i] <= drsp.quo;
                end
            end
        end
        if (out_load)
        begin
            oen_reg <= (ens_reg && exs_reg) ? 6'(eni_reg) : '0;
            oex_reg <= (ens_reg && exs_reg) ? 6'(exi_reg) : '0;
            for (int i = 0; i < 3; i++)
            begin
                opt_reg[i]   <= (ens_reg && exs_reg) ? enp_reg[i] : '0;
                opt_reg[3+i] <= (ens_reg && exs_reg) ? exp_reg[i] : '0;
            end
        end
    end

    assign vtx.ready      = (state_reg == ST_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.found      = found_reg;
    assign res.enter_edge = oen_reg;
    assign res.exit_edge  = oex_reg;
    assign res.enter_x    = opt_reg[0];
    assign res.enter_y    = opt_reg[1];
    assign res.enter_z    = opt_reg[2];
    assign res.exit_x     = opt_reg[3];
    assign res.exit_y     = opt_reg[4];
    assign res.exit_z     = opt_reg[5];

    // a waiting result request stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.found))
        else $error("result request dropped while stalled");

    // results are only loaded from the output state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside output state");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == ST_WAIT)
        else $error("stray divider completion");

    // vertex count saturates
    assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count overflow");

endmodule

/* dv/ppc_crossing_checker.sv */
`timescale 1ns / 1ps
module ppc_crossing_checker
    import ppc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    ppc_vertex_if.monitor vtx_mon,
    ppc_result_if.monitor res_mon,
    output int            fail_count,
    output int            pending_count,
    output int            crossings_seen
);
    typedef struct {
        logic               found;
        logic [5:0]         enter_edge;
        logic [5:0]         exit_edge;
        logic signed [15:0] enter_p [3];
        logic signed [15:0] exit_p [3];
    } crossing_t;

    crossing_t expected_crossings[$];

    longint nrm_x, nrm_y, nrm_z, pl_d;
    longint first_v [3];
    longint prev_v [3];
    longint prev_off, first_off;
    cls_t   cur_cls;
    int     vcount;
    bit     ent_seen, ext_seen;
    int     ent_idx, ext_idx;
    longint ent_p [3];
    longint ext_p [3];

    function automatic longint rdiv(longint n, longint d);
        longint un, ud, q;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q = (2 * un + ud) / (2 * ud);
        return neg ? -q : q;
    endfunction

    function automatic cls_t edge_cls(longint a, longint b, cls_t prev);
        if (b > 0)
        begin
            if (a > 0) return CLS_INFRONT;
            if (a < 0) return CLS_ENTERS;
            return prev == CLS_BEHIND ? CLS_ENTERS : CLS_INFRONT;
        end
        if (b < 0)
        begin
            if (a < 0) return CLS_BEHIND;
            if (a > 0) return CLS_EXITS;
            return prev == CLS_INFRONT ? CLS_EXITS : CLS_BEHIND;
        end
        if (a > 0) return CLS_INFRONT;
        if (a < 0) return CLS_BEHIND;
        return prev;
    endfunction

    task automatic walk_edge(input longint o [3], input longint a, input longint e [3],
                             input longint b, input int idx);
        longint den;
        if (ent_seen && ext_seen)
            return;
        cur_cls = edge_cls(a, b, cur_cls);
        den = a - b;
        if (cur_cls == CLS_ENTERS)
        begin
            ent_seen = 1;
            ent_idx = idx;
            for (int i = 0; i < 3; i++)
                ent_p[i] = den == 0 ? o[i] : rdiv(a * e[i] - b * o[i], den);
        end
        else if (cur_cls == CLS_EXITS)
        begin
            ext_seen = 1;
            ext_idx = idx;
            for (int i = 0; i < 3; i++)
                ext_p[i] = den == 0 ? o[i] : rdiv(a * e[i] - b * o[i], den);
        end
    endtask

    task automatic clear_poly();
        for (int i = 0; i < 3; i++)
        begin
            first_v[i] = 0; prev_v[i] = 0; ent_p[i] = 0; ext_p[i] = 0;
        end
        prev_off = 0; first_off = 0; cur_cls = CLS_UNKNOWN; vcount = 0;
        ent_seen = 0; ext_seen = 0; ent_idx = 0; ext_idx = 0;
    endtask

    task automatic take_vertex(input longint v [3], input bit last);
        longint off;
        int idx;
        crossing_t c;
        off = pl_d - (v[0] * nrm_x + v[1] * nrm_y + v[2] * nrm_z);
        if (vcount == 0)
        begin
            first_v = v;
            first_off = off;
        end
        else
            walk_edge(prev_v, prev_off, v, off, vcount - 1);
        idx = vcount > MAX_VERTICES - 1 ? MAX_VERTICES - 1 : vcount;
        if (vcount < MAX_VERTICES) vcount++;
        prev_v = v;
        prev_off = off;
        if (!last) return;
        walk_edge(v, off, first_v, first_off, idx);
        c.found = ent_seen && ext_seen;
        c.enter_edge = c.found ? 6'(ent_idx) : '0;
        c.exit_edge = c.found ? 6'(ext_idx) : '0;
        for (int i = 0; i < 3; i++)
        begin
            c.enter_p[i] = c.found ? 16'(ent_p[i]) : '0;
            c.exit_p[i] = c.found ? 16'(ext_p[i]) : '0;
        end
        expected_crossings.push_back(c);
        clear_poly();
    endtask

    task automatic report(input string f, input longint e, input longint a);
        $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint v [3];
        crossing_t c;
        logic signed [15:0] ae [3];
        logic signed [15:0] ax [3];
        if (!rst_n)
        begin
            nrm_x = 0; nrm_y = 0; nrm_z = 16384; pl_d = 0;
            clear_poly();
            fail_count = 0;
            crossings_seen = 0;
            expected_crossings.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    REG_NORMAL_X: nrm_x = longint'($signed(cfg_data[15:0]));
                    REG_NORMAL_Y: nrm_y = longint'($signed(cfg_data[15:0]));
                    REG_NORMAL_Z: nrm_z = longint'($signed(cfg_data[15:0]));
                    REG_PLANE_D:  pl_d = longint'($signed(cfg_data));
                    default:      pl_d = pl_d;
                endcase
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_crossings.size() == 0)
                begin
                    $display("%0t: unexpected result request", $time);
                    fail_count++;
                end
                else
                begin
                    c = expected_crossings.pop_front();
                    ae = '{res_mon.enter_x, res_mon.enter_y, res_mon.enter_z};
                    ax = '{res_mon.exit_x, res_mon.exit_y, res_mon.exit_z};
                    if (c.found) crossings_seen++;
                    if (res_mon.found !== c.found) report("found", c.found, res_mon.found);
                    if (res_mon.enter_edge !== c.enter_edge)
                        report("enter_edge", c.enter_edge, res_mon.enter_edge);
                    if (res_mon.exit_edge !== c.exit_edge)
                        report("exit_edge", c.exit_edge, res_mon.exit_edge);
                    for (int i = 0; i < 3; i++)
                    begin
                        if (ae[i] !== c.enter_p[i]) report("enter_point", c.enter_p[i], ae[i]);
                        if (ax[i] !== c.exit_p[i]) report("exit_point", c.exit_p[i], ax[i]);
                    end
                end
            end
            if (vtx_mon.valid && vtx_mon.ready)
            begin
                v[0] = vtx_mon.vertex_x; v[1] = vtx_mon.vertex_y; v[2] = vtx_mon.vertex_z;
                take_vertex(v, vtx_mon.is_last);
            end
            pending_count = expected_crossings.size();
        end
    end
endmodule

/* dv/tb_polygon_plane_crossing.sv */
`timescale 1ns / 1ps
module tb_polygon_plane_crossing;
    import ppc_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = REG_NORMAL_X;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending_count, crossings_seen;
    int          sent = 0;
    int          polygons = 0;
    longint      cycles = 0;

    ppc_vertex_if vtx();
    ppc_result_if res();

    polygon_plane_crossing DUT (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .vtx(vtx.sink), .res(res.source));

    ppc_crossing_checker checker_i (.clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .vtx_mon(vtx.monitor),
        .res_mon(res.monitor), .fail_count(fail_count), .pending_count(pending_count),
        .crossings_seen(crossings_seen));

    always #4 clk = ~clk;

    initial
    begin
        vtx.valid = 0; vtx.vertex_x = 0; vtx.vertex_y = 0; vtx.vertex_z = 0;
        vtx.is_last = 0;
        res.ready = 0;
    end

    // watchdog: allows for the slowest vertices plus gaps and stalls
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall per result, sometimes none at all
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            repeat (gap) @(posedge clk);
            res.ready <= 1;
            @(posedge clk);
            while (!res.valid) @(posedge clk);
            res.ready <= 0;
        end
    end

    // one vertex request; gap drawn per item
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input bit last, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            vtx.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        vtx.valid <= 1;
        vtx.vertex_x <= x; vtx.vertex_y <= y; vtx.vertex_z <= z; vtx.is_last <= last;
        @(posedge clk);
        while (!vtx.ready) @(posedge clk);
        sent++;
        if (last) polygons++;
    endtask

    task automatic drop_valid();
        vtx.valid <= 0;
        @(posedge clk);
    endtask

    // idle the sender until every result is out, then let the block settle
    task automatic drain();
        drop_valid();
        while (pending_count != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic set_plane(input int nx, input int ny, input int nz, input int d);
        drain();
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_PLANE_D, d);
    endtask

    // random polygon: mostly small coordinates spanning the plane, some full range
    task automatic random_polygon(input int nverts, input bit wide);
        logic [15:0] x, y, z;
        bit burst;
        burst = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < nverts; i++)
        begin
            if (wide)
            begin
                x = $urandom; y = $urandom; z = $urandom;
            end
            else
            begin
                x = 16'($signed($urandom_range(0, 400)) - 200);
                y = 16'($signed($urandom_range(0, 400)) - 200);
                z = ($urandom_range(0, 5) == 0) ? 16'd0
                    : 16'($signed($urandom_range(0, 400)) - 200);
            end
            send_vertex(x, y, z, i == nverts - 1, burst);
        end
    endtask

    initial
    begin
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: square crossing z=0 at reset plane
        send_vertex(0, 0, -10, 0, 0);
        send_vertex(10, 0, -10, 0, 0);
        send_vertex(10, 0, 10, 0, 0);
        send_vertex(0, 0, 10, 1, 0);
        // single vertex polygon
        send_vertex(5, 5, 5, 1, 0);
        // vertices on the plane carry the class, including an in-plane edge
        send_vertex(0, 0, 5, 0, 0);
        send_vertex(1, 0, 0, 0, 0);
        send_vertex(2, 0, 0, 0, 0);
        send_vertex(3, 0, -5, 0, 0);
        send_vertex(4, 0, 0, 1, 0);
        // triangle crossing the plane: enters on a regular edge, exits on the closing edge
        send_vertex(0, 0, 3, 0, 0);
        send_vertex(1, 0, 3, 0, 0);
        send_vertex(2, 0, -3, 1, 0);
        // extremes of coordinates
        send_vertex(16'h8000, 16'h7fff, 16'h8000, 0, 0);
        send_vertex(16'h7fff, 16'h8000, 16'h7fff, 0, 0);
        send_vertex(16'hffff, 16'h0000, 16'h8001, 1, 0);
        // pause until everything has come back
        drain();
        // saturating vertex count: 70 vertices
        for (int i = 0; i < 70; i++)
            send_vertex(16'(i), 16'(i * 3), (i % 9 < 4) ? 16'd7 : -16'sd7, i == 69, 1);

        // plane settings, extremes among them
        set_plane(16384, 0, 0, 0);
        for (int k = 0; k < 20; k++) random_polygon($urandom_range(1, 8), k < 2);
        set_plane(-16384, -16384, -16384, 32'h7fffffff);
        for (int k = 0; k < 10; k++) random_polygon($urandom_range(2, 6), 1);
        set_plane(0, 0, 0, 32'h80000000);
        for (int k = 0; k < 5; k++) random_polygon($urandom_range(1, 5), 1);
        // out-of-range register values are used as written
        set_plane(32'h7fff, 32'h8000, 16384, 0);
        for (int k = 0; k < 10; k++) random_polygon($urandom_range(2, 6), k < 3);
        set_plane(0, 0, 16384, 0);
        while (sent < 560)
        begin
            if ($urandom_range(0, 40) == 0)
                set_plane(16'($signed($urandom_range(0, 32768)) - 16384),
                          16'($signed($urandom_range(0, 32768)) - 16384),
                          16'($signed($urandom_range(0, 32768)) - 16384),
                          $signed($urandom_range(0, 20000)) - 10000);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 7);
            random_polygon(n, $urandom_range(0, 9) == 0);
        end

        drop_valid();
        while (pending_count != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("sent %0d vertices in %0d polygons, %0d crossing results",
                 sent, polygons, crossings_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
